// File: hw/rtl/rtch_pkg.sv
// ----------------------------------------------------------------------------
// rtch_pkg: shared types and constants for the ray/triangle closest-hit block
// Widths of the exact fixed-point terms, operand codes and the term program.
// ----------------------------------------------------------------------------
package rtch_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int W_COORD = 32;
    localparam int W_EDGE  = 33;
    localparam int W_DIST  = 31;
    localparam int W_WIDE  = 68;
    localparam int W_DIG   = 17;
    localparam int W_PROD  = W_WIDE + W_DIG;
    localparam int W_ACC   = 104;
    localparam int W_DIV   = W_ACC + 33;
    localparam int W_QUO   = 32;
    localparam int N_TERMS = 24;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;
    localparam logic [2:0] REG_LIMIT    = 3'd6;

    localparam logic [4:0] SRC_DX  = 5'd0;
    localparam logic [4:0] SRC_DY  = 5'd1;
    localparam logic [4:0] SRC_DZ  = 5'd2;
    localparam logic [4:0] SRC_E1X = 5'd3;
    localparam logic [4:0] SRC_E1Y = 5'd4;
    localparam logic [4:0] SRC_E1Z = 5'd5;
    localparam logic [4:0] SRC_E2X = 5'd6;
    localparam logic [4:0] SRC_E2Y = 5'd7;
    localparam logic [4:0] SRC_E2Z = 5'd8;
    localparam logic [4:0] SRC_SX  = 5'd9;
    localparam logic [4:0] SRC_SY  = 5'd10;
    localparam logic [4:0] SRC_SZ  = 5'd11;
    localparam logic [4:0] SRC_HX  = 5'd12;
    localparam logic [4:0] SRC_HY  = 5'd13;
    localparam logic [4:0] SRC_HZ  = 5'd14;
    localparam logic [4:0] SRC_QX  = 5'd15;
    localparam logic [4:0] SRC_QY  = 5'd16;
    localparam logic [4:0] SRC_QZ  = 5'd17;

    localparam logic [3:0] DST_HX  = 4'd0;
    localparam logic [3:0] DST_HY  = 4'd1;
    localparam logic [3:0] DST_HZ  = 4'd2;
    localparam logic [3:0] DST_QX  = 4'd3;
    localparam logic [3:0] DST_QY  = 4'd4;
    localparam logic [3:0] DST_QZ  = 4'd5;
    localparam logic [3:0] DST_DET = 4'd6;
    localparam logic [3:0] DST_U   = 4'd7;
    localparam logic [3:0] DST_V   = 4'd8;
    localparam logic [3:0] DST_T   = 4'd9;

    typedef struct packed {
        logic [2:0][W_EDGE-1:0] e1;
        logic [2:0][W_EDGE-1:0] e2;
        logic [2:0][W_EDGE-1:0] s;
        logic                   final_tri;
    } t_tri;

    typedef struct packed {
        logic [4:0] a_sel;
        logic [4:0] b_sel;
        logic       neg;
        logic [3:0] dest;
        logic       first;
        logic       last;
    } t_term;

    function automatic t_term term_at(input logic [4:0] idx);
        t_term t;
        begin
            case (idx)
                5'd0:    t = '{SRC_E2Z, SRC_DY,  1'b0, DST_HX,  1'b1, 1'b0};
                5'd1:    t = '{SRC_E2Y, SRC_DZ,  1'b1, DST_HX,  1'b0, 1'b1};
                5'd2:    t = '{SRC_E2X, SRC_DZ,  1'b0, DST_HY,  1'b1, 1'b0};
                5'd3:    t = '{SRC_E2Z, SRC_DX,  1'b1, DST_HY,  1'b0, 1'b1};
                5'd4:    t = '{SRC_E2Y, SRC_DX,  1'b0, DST_HZ,  1'b1, 1'b0};
                5'd5:    t = '{SRC_E2X, SRC_DY,  1'b1, DST_HZ,  1'b0, 1'b1};
                5'd6:    t = '{SRC_E1Z, SRC_SY,  1'b0, DST_QX,  1'b1, 1'b0};
                5'd7:    t = '{SRC_E1Y, SRC_SZ,  1'b1, DST_QX,  1'b0, 1'b1};
                5'd8:    t = '{SRC_E1X, SRC_SZ,  1'b0, DST_QY,  1'b1, 1'b0};
                5'd9:    t = '{SRC_E1Z, SRC_SX,  1'b1, DST_QY,  1'b0, 1'b1};
                5'd10:   t = '{SRC_E1Y, SRC_SX,  1'b0, DST_QZ,  1'b1, 1'b0};
                5'd11:   t = '{SRC_E1X, SRC_SY,  1'b1, DST_QZ,  1'b0, 1'b1};
                5'd12:   t = '{SRC_HX,  SRC_E1X, 1'b0, DST_DET, 1'b1, 1'b0};
                5'd13:   t = '{SRC_HY,  SRC_E1Y, 1'b0, DST_DET, 1'b0, 1'b0};
                5'd14:   t = '{SRC_HZ,  SRC_E1Z, 1'b0, DST_DET, 1'b0, 1'b1};
                5'd15:   t = '{SRC_HX,  SRC_SX,  1'b0, DST_U,   1'b1, 1'b0};
                5'd16:   t = '{SRC_HY,  SRC_SY,  1'b0, DST_U,   1'b0, 1'b0};
                5'd17:   t = '{SRC_HZ,  SRC_SZ,  1'b0, DST_U,   1'b0, 1'b1};
                5'd18:   t = '{SRC_QX,  SRC_DX,  1'b0, DST_V,   1'b1, 1'b0};
                5'd19:   t = '{SRC_QY,  SRC_DY,  1'b0, DST_V,   1'b0, 1'b0};
                5'd20:   t = '{SRC_QZ,  SRC_DZ,  1'b0, DST_V,   1'b0, 1'b1};
                5'd21:   t = '{SRC_QX,  SRC_E2X, 1'b0, DST_T,   1'b1, 1'b0};
                5'd22:   t = '{SRC_QY,  SRC_E2Y, 1'b0, DST_T,   1'b0, 1'b0};
                5'd23:   t = '{SRC_QZ,  SRC_E2Z, 1'b0, DST_T,   1'b0, 1'b1};
                default: t = '{SRC_DX,  SRC_DX,  1'b0, DST_T,   1'b1, 1'b1};
            endcase
            return t;
        end
    endfunction

endpackage

// File: hw/rtl/rtch_front.sv
// ----------------------------------------------------------------------------
// rtch_front: triangle intake
// Takes one triangle per transfer and forms the edges and the origin offset.
// ----------------------------------------------------------------------------
module rtch_front import rtch_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [9*W_COORD-1:0]    i_data,
    input  logic                    i_last,
    input  logic [2:0][W_COORD-1:0] i_origin,
    input  logic                    i_q_ready,
    output logic                    o_ready,
    output logic                    o_push,
    output t_tri                    o_tri
);

    logic r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (o_push) begin
            r_seen <= 1'b1;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_tri.e1[k] = W_EDGE'($signed(i_data[(3+k)*W_COORD +: W_COORD]))
                        - W_EDGE'($signed(i_data[k*W_COORD +: W_COORD]));
            o_tri.e2[k] = W_EDGE'($signed(i_data[(6+k)*W_COORD +: W_COORD]))
                        - W_EDGE'($signed(i_data[k*W_COORD +: W_COORD]));
            o_tri.s[k]  = W_EDGE'($signed(i_origin[k]))
                        - W_EDGE'($signed(i_data[k*W_COORD +: W_COORD]));
        end
        o_tri.final_tri = i_last | (r_seen & 1'b0);
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid & i_q_ready;

endmodule

// File: hw/rtl/rtch_queue.sv
// ----------------------------------------------------------------------------
// rtch_queue: triangle queue
// Short first-in first-out buffer between the intake and the test engine.
// ----------------------------------------------------------------------------
module rtch_queue import rtch_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_tri i_data,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_tri o_data
);

    localparam int W_PTR = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int W_CNT = $clog2(QUEUE_DEPTH + 1);

    t_tri             r_mem [QUEUE_DEPTH];
    logic [W_PTR-1:0] r_wr;
    logic [W_PTR-1:0] r_rd;
    logic [W_CNT-1:0] r_cnt;

    assign o_ready = (r_cnt != W_CNT'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == W_PTR'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == W_PTR'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + W_CNT'(i_push) - W_CNT'(i_pop);
        end
    end

endmodule

// File: hw/rtl/rtch_back.sv
// ----------------------------------------------------------------------------
// rtch_back: intersection engine
// Digit-serial multiply-accumulate over the term program, bounds checks,
// restoring division for t, nearest-hit tracking and the result register.
// ----------------------------------------------------------------------------
module rtch_back import rtch_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  t_tri                    i_tri,
    output logic                    o_pop,
    input  logic [2:0][W_COORD-1:0] i_dir,
    input  logic [W_DIST-1:0]       i_limit,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_hit,
    output logic [W_DIST-1:0]       o_dist
);

    localparam int EPS_SH = (3 * FRACTION_BITS >= 30) ? 3 * FRACTION_BITS - 30 : 0;
    localparam logic [W_ACC-1:0] EPS =
        (3 * FRACTION_BITS >= 30) ? (W_ACC'(1) << EPS_SH) : '0;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_ACC    = 3'd2;
    localparam logic [2:0] S_NORM   = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_DECIDE = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [2:0]                r_state;
    logic [4:0]                r_term;
    logic [1:0]                r_digit;
    logic signed [W_ACC-1:0]   r_acc;
    logic signed [W_PROD-1:0]  r_prod;
    logic [2:0][W_WIDE-1:0]    r_h;
    logic [2:0][W_WIDE-1:0]    r_q;
    logic signed [W_ACC-1:0]   r_det, r_u, r_v, r_t;
    logic [W_DIV-1:0]          r_rem, r_dsr;
    logic [W_QUO-1:0]          r_quo;
    logic [4:0]                r_cnt;
    logic                      r_ok;
    logic                      r_any;
    logic [W_DIST-1:0]         r_near;
    logic                      r_ovalid;
    logic                      r_ohit;
    logic [W_DIST-1:0]         r_odist;

    t_term                     term;
    logic signed [W_WIDE-1:0]  a_val;
    logic signed [W_EDGE-1:0]  b_val;
    logic [47:0]               b_ext;
    logic [15:0]               dig;
    logic signed [W_DIG-1:0]   dig_s;
    logic signed [W_PROD-1:0]  n_prod;
    logic signed [W_ACC-1:0]   p_ext, p_sh, acc_base, n_acc;
    logic signed [W_ACC:0]     uv_sum;
    logic [W_DIV-1:0]          t_shf, t_sh20, det_u, det_sh32;
    logic                      fail, ovf, accept, load_out;

    assign term = term_at(r_term);

    always_comb begin
        unique case (term.a_sel)
            SRC_DX:  a_val = W_WIDE'($signed(i_dir[0]));
            SRC_DY:  a_val = W_WIDE'($signed(i_dir[1]));
            SRC_DZ:  a_val = W_WIDE'($signed(i_dir[2]));
            SRC_E1X: a_val = W_WIDE'($signed(i_tri.e1[0]));
            SRC_E1Y: a_val = W_WIDE'($signed(i_tri.e1[1]));
            SRC_E1Z: a_val = W_WIDE'($signed(i_tri.e1[2]));
            SRC_E2X: a_val = W_WIDE'($signed(i_tri.e2[0]));
            SRC_E2Y: a_val = W_WIDE'($signed(i_tri.e2[1]));
            SRC_E2Z: a_val = W_WIDE'($signed(i_tri.e2[2]));
            SRC_SX:  a_val = W_WIDE'($signed(i_tri.s[0]));
            SRC_SY:  a_val = W_WIDE'($signed(i_tri.s[1]));
            SRC_SZ:  a_val = W_WIDE'($signed(i_tri.s[2]));
            SRC_HX:  a_val = $signed(r_h[0]);
            SRC_HY:  a_val = $signed(r_h[1]);
            SRC_HZ:  a_val = $signed(r_h[2]);
            SRC_QX:  a_val = $signed(r_q[0]);
            SRC_QY:  a_val = $signed(r_q[1]);
            SRC_QZ:  a_val = $signed(r_q[2]);
            default: a_val = '0;
        endcase
    end

    always_comb begin
        unique case (term.b_sel)
            SRC_DX:  b_val = W_EDGE'($signed(i_dir[0]));
            SRC_DY:  b_val = W_EDGE'($signed(i_dir[1]));
            SRC_DZ:  b_val = W_EDGE'($signed(i_dir[2]));
            SRC_E1X: b_val = $signed(i_tri.e1[0]);
            SRC_E1Y: b_val = $signed(i_tri.e1[1]);
            SRC_E1Z: b_val = $signed(i_tri.e1[2]);
            SRC_E2X: b_val = $signed(i_tri.e2[0]);
            SRC_E2Y: b_val = $signed(i_tri.e2[1]);
            SRC_E2Z: b_val = $signed(i_tri.e2[2]);
            SRC_SX:  b_val = $signed(i_tri.s[0]);
            SRC_SY:  b_val = $signed(i_tri.s[1]);
            SRC_SZ:  b_val = $signed(i_tri.s[2]);
            default: b_val = '0;
        endcase
    end

    always_comb begin
        b_ext    = 48'(b_val);
        dig      = b_ext[{r_digit, 4'b0000} +: 16];
        dig_s    = (r_digit == 2'd2) ? $signed({dig[15], dig}) : $signed({1'b0, dig});
        n_prod   = a_val * dig_s;
        p_ext    = W_ACC'(r_prod);
        p_sh     = p_ext <<< {r_digit, 4'b0000};
        acc_base = (term.first && r_digit == 2'd0) ? '0 : r_acc;
        n_acc    = term.neg ? acc_base - p_sh : acc_base + p_sh;

        uv_sum   = (W_ACC + 1)'(r_u) + (W_ACC + 1)'(r_v);
        t_shf    = W_DIV'(unsigned'(r_t)) << FRACTION_BITS;
        t_sh20   = W_DIV'(unsigned'(r_t)) << 20;
        det_u    = W_DIV'(unsigned'(r_det));
        det_sh32 = det_u << 32;
        fail     = (unsigned'(r_det) <= EPS) || r_u[W_ACC-1] || (r_u > r_det)
                || r_v[W_ACC-1] || (uv_sum > (W_ACC + 1)'(r_det))
                || r_t[W_ACC-1] || (t_sh20 <= det_u);
        ovf      = (t_shf >= det_sh32);
        accept   = r_ok && ((r_quo < W_QUO'(i_limit))
                || (r_quo == W_QUO'(i_limit) && r_rem == '0));
        load_out = (r_state == S_EMIT) && (!r_ovalid || i_ready);
    end

    assign o_pop = ((r_state == S_DECIDE) && !i_tri.final_tri) || load_out;

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod <= n_prod;
        end
        if (r_state == S_ACC) begin
            r_acc <= n_acc;
            if (r_digit == 2'd2 && term.last) begin
                unique case (term.dest)
                    DST_HX:  r_h[0] <= n_acc[W_WIDE-1:0];
                    DST_HY:  r_h[1] <= n_acc[W_WIDE-1:0];
                    DST_HZ:  r_h[2] <= n_acc[W_WIDE-1:0];
                    DST_QX:  r_q[0] <= n_acc[W_WIDE-1:0];
                    DST_QY:  r_q[1] <= n_acc[W_WIDE-1:0];
                    DST_QZ:  r_q[2] <= n_acc[W_WIDE-1:0];
                    DST_DET: r_det  <= n_acc;
                    DST_U:   r_u    <= n_acc;
                    DST_V:   r_v    <= n_acc;
                    DST_T:   r_t    <= n_acc;
                    default: r_acc  <= n_acc;
                endcase
            end
        end
        if (r_state == S_NORM && r_det[W_ACC-1]) begin
            r_det <= -r_det;
            r_u   <= -r_u;
            r_v   <= -r_v;
            r_t   <= -r_t;
        end
        if (r_state == S_CHECK) begin
            r_rem <= t_shf;
            r_dsr <= det_u << 31;
            r_quo <= '0;
            r_cnt <= '0;
        end
        if (r_state == S_DIV) begin
            if (r_rem >= r_dsr) begin
                r_rem <= r_rem - r_dsr;
                r_quo <= {r_quo[W_QUO-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[W_QUO-2:0], 1'b0};
            end
            r_dsr <= r_dsr >> 1;
            r_cnt <= r_cnt + 1'b1;
        end
        if (load_out) begin
            r_ohit  <= r_any;
            r_odist <= r_any ? r_near : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_term   <= '0;
            r_digit  <= '0;
            r_ok     <= 1'b0;
            r_any    <= 1'b0;
            r_near   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_term  <= '0;
                        r_digit <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_digit == 2'd2) begin
                        r_digit <= '0;
                        if (r_term == 5'(N_TERMS - 1)) begin
                            r_state <= S_NORM;
                        end else begin
                            r_term  <= r_term + 1'b1;
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_digit <= r_digit + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_NORM: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_ok    <= !fail && !ovf;
                    r_state <= (fail || ovf) ? S_DECIDE : S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == 5'd31) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (accept && (!r_any || r_quo[W_DIST-1:0] < r_near)) begin
                        r_any  <= 1'b1;
                        r_near <= r_quo[W_DIST-1:0];
                    end
                    r_state <= i_tri.final_tri ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (load_out) begin
                        r_any   <= 1'b0;
                        r_near  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_hit   = r_ohit;
    assign o_dist  = r_odist;

endmodule

// File: hw/rtl/ray_triangle_closest_hit.sv
// Each triangle runs 72 multiply and accumulate steps in the engine; one that
// passes the bounds checks then also runs a 32-step restoring divider.
// Throughput: one triangle per engine pass; a two-entry queue takes new ones.
// After the last triangle's pass the result waits for a free output register.
// Reset is synchronous and active low; it restores the register defaults.
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit: closest-hit Moller-Trumbore ray/triangle tester
// Streams triangles against a ray held in registers and reports the nearest
// accepted hit distance on the last triangle of each list.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit import rtch_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // vert_a_x, vert_a_y, vert_a_z, vert_b_x, ..., vert_c_z (32 bits each)
    input  logic [9*W_COORD-1:0] i_s_tdata,
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // hit_found [0], hit_distance [31:1]
    output logic [31:0]          o_m_tdata,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [4:0]           i_paddr,
    input  logic [31:0]          i_pwdata,
    output logic [31:0]          o_prdata,
    output logic                 o_pready
);

    logic [2:0][W_COORD-1:0] r_origin;
    logic [2:0][W_COORD-1:0] r_dir;
    logic [W_DIST-1:0]       r_limit;
    logic [2:0]              reg_idx;
    logic                    push, q_ready, q_valid, pop, hit;
    logic [W_DIST-1:0]       near_dist;
    t_tri                    tri_in, tri_head;

    assign o_pready = 1'b1;
    assign reg_idx  = i_paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= '0;
            r_dir    <= {W_COORD'(0), W_COORD'(0), W_COORD'(1) << FRACTION_BITS};
            r_limit  <= '1;
        end else if (i_psel && i_penable && i_pwrite && o_pready) begin
            unique case (reg_idx)
                REG_ORIGIN_X: r_origin[0] <= i_pwdata;
                REG_ORIGIN_Y: r_origin[1] <= i_pwdata;
                REG_ORIGIN_Z: r_origin[2] <= i_pwdata;
                REG_DIR_X:    r_dir[0]    <= i_pwdata;
                REG_DIR_Y:    r_dir[1]    <= i_pwdata;
                REG_DIR_Z:    r_dir[2]    <= i_pwdata;
                REG_LIMIT:    r_limit     <= i_pwdata[W_DIST-1:0];
                default:      r_limit     <= r_limit;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ORIGIN_X: o_prdata = r_origin[0];
            REG_ORIGIN_Y: o_prdata = r_origin[1];
            REG_ORIGIN_Z: o_prdata = r_origin[2];
            REG_DIR_X:    o_prdata = r_dir[0];
            REG_DIR_Y:    o_prdata = r_dir[1];
            REG_DIR_Z:    o_prdata = r_dir[2];
            REG_LIMIT:    o_prdata = 32'(r_limit);
            default:      o_prdata = '0;
        endcase
    end

    rtch_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_data    (i_s_tdata),
        .i_last    (i_s_tlast),
        .i_origin  (r_origin),
        .i_q_ready (q_ready),
        .o_ready   (o_s_tready),
        .o_push    (push),
        .o_tri     (tri_in)
    );

    rtch_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (tri_in),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (tri_head)
    );

    rtch_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_tri     (tri_head),
        .o_pop     (pop),
        .i_dir     (r_dir),
        .i_limit   (r_limit),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_hit     (hit),
        .o_dist    (near_dist)
    );

    assign o_m_tdata = {near_dist, hit};

endmodule

// File: hw/rtl/rtch_checker.sv
// ----------------------------------------------------------------------------
// rtch_checker: port-level checks for the closest-hit block
// Watches the top-level ports and flags results that break the contract.
// ----------------------------------------------------------------------------
module rtch_checker import rtch_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic [9*W_COORD-1:0] i_s_tdata,
    input logic                 i_s_tlast,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [31:0]          o_m_tdata,
    input logic                 i_psel,
    input logic                 i_penable,
    input logic                 i_pwrite,
    input logic [4:0]           i_paddr,
    input logic [31:0]          i_pwdata,
    input logic [31:0]          o_prdata,
    input logic                 o_pready
);

    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[31:1] == '0))
        else $error("distance not zero on a miss");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result shown right after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable) |-> o_pready)
        else $error("configuration access stalled");

endmodule

bind ray_triangle_closest_hit rtch_checker u_rtch_checker (.*);

// File: tb/sv/tb_ray_triangle_closest_hit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ray_triangle_closest_hit: self-checking testbench for the closest-hit unit
// Streams triangle lists against rays set over the register port. Each list's
// nearest hit is worked out in exact wide-integer arithmetic and compared with
// the block's result. Directed cases come first, then random lists under
// several ray settings and idling patterns, with one long output stall.
// ----------------------------------------------------------------------------
module tb_ray_triangle_closest_hit;
    import rtch_pkg::*;

    localparam int ONE = 65536;
    localparam int SETTLE_CYCLES = 700;

    typedef logic signed [159:0] t_wint;
    typedef logic signed [31:0] t_coord;
    typedef t_coord t_verts [9];

    typedef struct {
        bit          hit;
        logic [30:0] hit_dist;
    } t_hit_rec;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [287:0] i_s_tdata;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [4:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    ray_triangle_closest_hit u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tlast (i_s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // Ray registers and running hit state of the predictor.
    t_coord      ray_org [3];
    t_coord      ray_dir [3];
    logic [30:0] ray_limit;
    bit          nearest_valid;
    logic [30:0] nearest_dist;

    t_hit_rec    pending_hits[$];
    int          mismatch_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_req;
    int          hold_cnt;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    initial begin
        #(12 * 5000000);
        $display("** ray_triangle_closest_hit: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        if (hold_req && hold_cnt == 0) begin
            hold_cnt <= 3000;
            hold_req <= 1'b0;
            i_m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(negedge i_clk) begin
        t_hit_rec exp_rec;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_hits.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result transfer, actual hit=%0b dist=%0d",
                         $time, o_m_tdata[0], o_m_tdata[31:1]);
            end else begin
                exp_rec = pending_hits.pop_front();
                if (o_m_tdata[0] !== exp_rec.hit) begin
                    mismatch_count++;
                    $display("%0t: hit_found expected %0b actual %0b",
                             $time, exp_rec.hit, o_m_tdata[0]);
                end
                if (o_m_tdata[31:1] !== exp_rec.hit_dist) begin
                    mismatch_count++;
                    $display("%0t: hit_distance expected %0d actual %0d",
                             $time, exp_rec.hit_dist, o_m_tdata[31:1]);
                end
            end
        end
    end

    function automatic void intersect_triangle(input t_verts v);
        t_wint d[3], e1[3], e2[3], s[3], h[3], q[3];
        t_wint det, un, vn, tn, quo, rem;
        for (int k = 0; k < 3; k++) begin
            d[k]  = t_wint'(ray_dir[k]);
            e1[k] = t_wint'(v[3+k]) - t_wint'(v[k]);
            e2[k] = t_wint'(v[6+k]) - t_wint'(v[k]);
            s[k]  = t_wint'(ray_org[k]) - t_wint'(v[k]);
        end
        h[0] = d[1] * e2[2] - d[2] * e2[1];
        h[1] = d[2] * e2[0] - d[0] * e2[2];
        h[2] = d[0] * e2[1] - d[1] * e2[0];
        q[0] = s[1] * e1[2] - s[2] * e1[1];
        q[1] = s[2] * e1[0] - s[0] * e1[2];
        q[2] = s[0] * e1[1] - s[1] * e1[0];
        det = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
        un  = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
        vn  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
        tn  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
        if (det < 0) begin
            det = -det;
            un  = -un;
            vn  = -vn;
            tn  = -tn;
        end
        if (det <= (t_wint'(1) <<< (3 * FRACTION_BITS_DEF - 30))) return;
        if (un < 0 || un > det) return;
        if (vn < 0 || un + vn > det) return;
        if (tn < 0 || (tn <<< 20) <= det) return;
        quo = (tn <<< FRACTION_BITS_DEF) / det;
        rem = (tn <<< FRACTION_BITS_DEF) % det;
        if (quo > t_wint'(ray_limit)) return;
        if (quo == t_wint'(ray_limit) && rem != 0) return;
        if (!nearest_valid || quo < t_wint'(nearest_dist)) begin
            nearest_dist  = quo[30:0];
            nearest_valid = 1'b1;
        end
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    task automatic set_ray(input t_coord ox, input t_coord oy, input t_coord oz,
                           input t_coord dx, input t_coord dy, input t_coord dz,
                           input logic [30:0] lim);
        apb_write(REG_ORIGIN_X, ox);
        apb_write(REG_ORIGIN_Y, oy);
        apb_write(REG_ORIGIN_Z, oz);
        apb_write(REG_DIR_X, dx);
        apb_write(REG_DIR_Y, dy);
        apb_write(REG_DIR_Z, dz);
        apb_write(REG_LIMIT, {1'b0, lim});
        ray_org[0] = ox;
        ray_org[1] = oy;
        ray_org[2] = oz;
        ray_dir[0] = dx;
        ray_dir[1] = dy;
        ray_dir[2] = dz;
        ray_limit  = lim;
    endtask

    task automatic send_triangle(input t_verts v, input bit last);
        bit rdy;
        int gap;
        t_hit_rec exp_hit;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tlast  <= last;
        for (int k = 0; k < 9; k++) i_s_tdata[32*k +: 32] <= v[k];
        do begin
            @(negedge i_clk);
            rdy = o_s_tready;
            @(posedge i_clk);
        end while (!rdy);
        intersect_triangle(v);
        if (last) begin
            exp_hit.hit      = nearest_valid;
            exp_hit.hit_dist = nearest_valid ? nearest_dist : 31'd0;
            pending_hits     = {pending_hits, exp_hit};
            nearest_valid    = 1'b0;
            nearest_dist     = '0;
        end
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_hits.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_verts make_tri(input int ax, input int ay, input int az,
                                        input int bx, input int by, input int bz,
                                        input int cx, input int cy, input int cz);
        t_verts v;
        v[0] = ax; v[1] = ay; v[2] = az;
        v[3] = bx; v[4] = by; v[5] = bz;
        v[6] = cx; v[7] = cy; v[8] = cz;
        return v;
    endfunction

    function automatic t_verts noise_tri();
        t_verts v;
        for (int k = 0; k < 9; k++) v[k] = $urandom;
        return v;
    endfunction

    // Builds a triangle around a point on the ray so that many of them are hit.
    function automatic t_verts aimed_tri();
        t_verts v;
        longint t_q;
        longint pt;
        t_q = $urandom_range(6 * ONE);
        for (int k = 0; k < 3; k++) begin
            pt = longint'(ray_org[k]) + ((longint'(ray_dir[k]) * t_q) >>> 16);
            v[k]   = t_coord'(pt + $urandom_range(2 * ONE) - ONE);
            v[3+k] = t_coord'(pt + $urandom_range(2 * ONE) - ONE);
            v[6+k] = t_coord'(pt + $urandom_range(2 * ONE) - ONE);
        end
        return v;
    endfunction

    function automatic t_coord small_coord(input int span);
        return t_coord'($urandom_range(2 * span) - span);
    endfunction

    task automatic send_random_lists(input int n_items, input int noise_pct);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(99) < noise_pct) send_triangle(noise_tri(), i == len - 1);
                else send_triangle(aimed_tri(), i == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic test_directed_defaults();
        // Ray from the origin along +x; triangle in the plane x = 2 is hit at t = 2.
        send_triangle(make_tri(2*ONE, -ONE, -ONE, 2*ONE, 3*ONE, -ONE, 2*ONE, -ONE, 3*ONE), 1);
        send_triangle(make_tri(2*ONE, 0, 0, 2*ONE, 0, 0, 2*ONE, 0, 0), 1);
        send_triangle(make_tri(ONE, ONE, -ONE, ONE, 3*ONE, -ONE, ONE, ONE, 3*ONE), 1);
        send_triangle(make_tri(-2*ONE, -ONE, -ONE, -2*ONE, 3*ONE, -ONE,
                               -2*ONE, -ONE, 3*ONE), 1);
        send_triangle(make_tri(0, -ONE, 0, 5*ONE, ONE, 0, 3*ONE, 2*ONE, 0), 1);
        send_triangle(make_tri(5*ONE, -ONE, -ONE, 5*ONE, 3*ONE, -ONE, 5*ONE, -ONE, 3*ONE), 0);
        send_triangle(make_tri(3*ONE, -ONE, -ONE, 3*ONE, 3*ONE, -ONE, 3*ONE, -ONE, 3*ONE), 0);
        send_triangle(make_tri(3*ONE, -ONE, -ONE, 3*ONE, -ONE, 3*ONE, 3*ONE, 3*ONE, -ONE), 1);
        send_triangle(make_tri(1, -ONE, -ONE, 1, 3*ONE, -ONE, 1, -ONE, 3*ONE), 1);
        send_triangle(make_tri(0, -ONE, -ONE, 0, 3*ONE, -ONE, 0, -ONE, 3*ONE), 1);
        send_triangle(make_tri(2*ONE, 0, 0, 2*ONE, ONE, 0, 2*ONE, 0, ONE), 1);
        send_triangle(make_tri(2*ONE, ONE, ONE, 2*ONE, 2*ONE, ONE, 2*ONE, ONE, 2*ONE), 1);
        wait_idle();
        set_ray(0, 0, 0, ONE, 0, 0, 31'(2 * ONE));
        send_triangle(make_tri(2*ONE, -ONE, -ONE, 2*ONE, 3*ONE, -ONE, 2*ONE, -ONE, 3*ONE), 1);
        send_triangle(make_tri(2*ONE + 1, -ONE, -ONE, 2*ONE + 1, 3*ONE, -ONE,
                               2*ONE + 1, -ONE, 3*ONE), 1);
        wait_idle();
        set_ray(0, 0, 0, 3*ONE, 0, 0, 31'(ONE));
        send_triangle(make_tri(2*ONE, -ONE, -ONE, 2*ONE, 3*ONE, -ONE, 2*ONE, -ONE, 3*ONE), 1);
        wait_idle();
        set_ray(0, 0, 0, 8*ONE, 0, 0, 31'h7FFFFFFF);
        send_triangle(make_tri(1, -ONE, -ONE, 1, 3*ONE, -ONE, 1, -ONE, 3*ONE), 1);
        send_triangle(make_tri(2, -ONE, -ONE, 2, 3*ONE, -ONE, 2, -ONE, 3*ONE), 1);
        wait_idle();
        set_ray(0, 0, 0, 0, 0, 0, 31'h7FFFFFFF);
        send_triangle(make_tri(2*ONE, -ONE, -ONE, 2*ONE, 3*ONE, -ONE, 2*ONE, -ONE, 3*ONE), 1);
        wait_idle();
    endtask

    task automatic test_extreme_rays();
        set_ray(32'sh80000000, 32'sh80000000, 32'sh80000000,
                32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 31'd0);
        send_random_lists(40, 100);
        wait_idle();
        set_ray(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 31'h7FFFFFFF);
        send_random_lists(40, 100);
        wait_idle();
        set_ray(0, 0, 0, ONE, 0, 0, 31'd0);
        send_random_lists(30, 10);
        wait_idle();
    endtask

    task automatic test_random_rays();
        logic [30:0] lim;
        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 78 : 0;
            rx_idle_pct = (mode == 0) ? 78 : (mode == 1) ? 35 : 0;
            for (int ph = 0; ph < 3; ph++) begin
                lim = ($urandom_range(1)) ? 31'h7FFFFFFF : 31'($urandom_range(8 * ONE));
                set_ray(small_coord(8 * ONE), small_coord(8 * ONE), small_coord(8 * ONE),
                        small_coord(2 * ONE), small_coord(2 * ONE), small_coord(2 * ONE), lim);
                send_random_lists(130, 15);
                wait_idle();
            end
        end
    endtask

    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_ray(0, 0, 0, ONE, ONE / 2, -ONE / 4, 31'h7FFFFFFF);
        hold_req <= 1'b1;
        for (int i = 0; i < 30; i++) send_triangle(aimed_tri(), 1);
        wait_idle();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tlast     = 1'b0;
        i_m_tready    = 1'b0;
        i_psel        = 1'b0;
        i_penable     = 1'b0;
        i_pwrite      = 1'b0;
        i_paddr       = '0;
        i_pwdata      = '0;
        hold_req      = 1'b0;
        hold_cnt      = 0;
        tx_idle_pct   = 35;
        rx_idle_pct   = 78;
        mismatch_count = 0;
        ray_org       = '{0, 0, 0};
        ray_dir       = '{ONE, 0, 0};
        ray_limit     = 31'h7FFFFFFF;
        nearest_valid = 1'b0;
        nearest_dist  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_defaults();
        test_extreme_rays();
        test_random_rays();
        test_output_backpressure();

        if (pending_hits.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d expected results never arrived", $time, pending_hits.size());
        end
        if (mismatch_count == 0) begin
            $display("** ray_triangle_closest_hit: PASSED **");
        end else begin
            $display("** ray_triangle_closest_hit: FAILED **");
        end
        $finish;
    end

endmodule

// File: ray_triangle_closest_hit.f
hw/rtl/rtch_pkg.sv
hw/rtl/rtch_front.sv
hw/rtl/rtch_queue.sv
hw/rtl/rtch_back.sv
hw/rtl/ray_triangle_closest_hit.sv
hw/rtl/rtch_checker.sv
tb/sv/tb_ray_triangle_closest_hit.sv
